@@ rtl/wtfac_pkg.sv @@
// ============================================================================
// wtfac_pkg - shared types and constants for the wheel trial factoriser
// Holds the result kinds, controller states, divider status and the 2-3-5
// wheel step table.
// ============================================================================
package wtfac_pkg;

    localparam int NUM_W       = 64;   // width of the number and value ports
    localparam int LIMIT_W     = 32;   // width of the iteration limit register
    localparam int DEF_WIDTH   = 64;   // default working width
    localparam int MAX_RESULTS = 64;   // most results in one run
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int POS_W       = 4;
    localparam int STEP_W      = 3;

    localparam logic [POS_W-1:0] WHEEL_LAST = 4'd10;
    localparam logic [POS_W-1:0] WHEEL_LOOP = 4'd3;

    // Register index, taken from the word address bit of paddr
    localparam logic REG_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        KIND_DIVISOR  = 2'd0,
        KIND_COFACTOR = 2'd1,
        KIND_GAVE_UP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRY,
        S_DIV,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Step to the next candidate from wheel position pos
    function automatic logic [STEP_W-1:0] wheel_step(input logic [POS_W-1:0] pos);
        logic [STEP_W-1:0] step;
        case (pos)
            4'd0:    step = 3'd1;
            4'd1:    step = 3'd2;
            4'd2:    step = 3'd2;
            4'd3:    step = 3'd4;
            4'd4:    step = 3'd2;
            4'd5:    step = 3'd4;
            4'd6:    step = 3'd2;
            4'd7:    step = 3'd4;
            4'd8:    step = 3'd6;
            4'd9:    step = 3'd2;
            4'd10:   step = 3'd6;
            default: step = 3'd1;
        endcase
        return step;
    endfunction

    // Wrap back to the start of the repeating eight steps
    function automatic logic [POS_W-1:0] wheel_next(input logic [POS_W-1:0] pos);
        return (pos == WHEEL_LAST) ? WHEEL_LOOP : POS_W'(pos + 1'b1);
    endfunction

endpackage

@@ rtl/wtfac_div.sv @@
// ============================================================================
// wtfac_div - radix-2 digit-recurrence divider
// Shifts the dividend in one bit a cycle and retires one quotient digit a
// cycle. Divisor must be held during the run.
// ============================================================================
module wtfac_div #(
    parameter int WIDTH = wtfac_pkg::DEF_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WIDTH-1:0]      i_dividend,
    input  logic [WIDTH-1:0]      i_divisor,
    output logic [WIDTH-1:0]      o_quotient,
    output logic [WIDTH-1:0]      o_remainder,
    output wtfac_pkg::t_div_stat  o_stat
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // Bring down the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[WIDTH-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                r_rem <= diff[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= trial[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ rtl/wheel_trial_factorizer.sv @@
// ============================================================================
// wheel_trial_factorizer - trial-division factoriser on a 2-3-5 wheel
// Takes one number per transaction and returns its factors, then the
// remaining cofactor or a gave-up result, the last one flagged.
// ============================================================================
// One number is worked at a time. Each trial candidate passes through S_TRY,
// which checks the limit and launches the bit-serial divider (one quotient
// digit per cycle), S_DIV, which waits for its done flag, and S_CHECK, which
// decides. The candidate square test comes from the same division, since
// cand*cand > n exactly when cand > n / cand. About 8/30 of the integers up
// to the square root of the cofactor are tried as candidates.
// A new number is taken as soon as the previous run has produced its last
// result, even while that result still waits in the output register.
// iteration_limit lives at byte address 0 of the APB port; zero disables it.
module wheel_trial_factorizer #(
    parameter int WIDTH = wtfac_pkg::DEF_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // number transactions
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [wtfac_pkg::NUM_W-1:0]       i_number,
    // result transactions
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wtfac_pkg::NUM_W-1:0]       o_value,
    output logic [1:0]                        o_kind,
    output logic                              o_last,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wtfac_pkg::PADDR_W-1:0]     paddr,
    input  logic [wtfac_pkg::PDATA_W-1:0]     pwdata,
    output logic [wtfac_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [wtfac_pkg::LIMIT_W-1:0] r_limit;

    assign pready = 1'b1;

    // Decode on the word address bit; byte offsets are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == wtfac_pkg::REG_LIMIT) begin
            r_limit <= pwdata;
        end
    end

    assign prdata = (paddr[2] == wtfac_pkg::REG_LIMIT) ? r_limit : '0;

    // ------------------------------------------------------------------
    // Run state
    // ------------------------------------------------------------------
    wtfac_pkg::t_state              r_state, n_state;
    logic [WIDTH-1:0]               r_num, n_num;     // current cofactor
    logic [WIDTH-1:0]               r_cand, n_cand;   // trial candidate
    logic [wtfac_pkg::POS_W-1:0]    r_pos, n_pos;     // wheel position
    logic [wtfac_pkg::LIMIT_W-1:0]  r_tries, n_tries; // misses since last result
    logic [wtfac_pkg::CNT_W-1:0]    r_count, n_count; // results emitted so far

    // Output register
    logic                           r_out_valid;
    logic [WIDTH-1:0]               r_out_value;
    wtfac_pkg::t_kind               r_out_kind;
    logic                           r_out_last;

    // Divider
    logic                           div_start;
    logic [WIDTH-1:0]               div_q;
    logic [WIDTH-1:0]               div_r;
    wtfac_pkg::t_div_stat           div_stat;

    // Decision signals
    logic                           out_free;
    logic                           emit;
    logic [WIDTH-1:0]               em_value;
    wtfac_pkg::t_kind               em_kind;
    logic                           em_last;
    logic                           cand_over;
    logic                           rem_zero;
    logic [WIDTH:0]                 step_sum;

    wtfac_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_num),
        .i_divisor   (r_cand),
        .o_quotient  (div_q),
        .o_remainder (div_r),
        .o_stat      (div_stat)
    );

    // Square exceeds the cofactor exactly when the candidate beats the quotient
    assign cand_over = r_cand > div_q;
    assign rem_zero  = (div_r == '0);
    // Carry out of the add means the candidate wrapped
    assign step_sum  = {1'b0, r_cand} + (WIDTH + 1)'(wtfac_pkg::wheel_step(r_pos));

    assign out_free  = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtfac_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_cand  <= n_cand;
        r_pos   <= n_pos;
        r_tries <= n_tries;
        r_count <= n_count;
    end

    always_comb begin
        n_state   = r_state;
        n_num     = r_num;
        n_cand    = r_cand;
        n_pos     = r_pos;
        n_tries   = r_tries;
        n_count   = r_count;
        emit      = 1'b0;
        em_value  = '0;
        em_kind   = wtfac_pkg::KIND_GAVE_UP;
        em_last   = 1'b1;
        div_start = 1'b0;
        o_in_ready = (r_state == wtfac_pkg::S_IDLE);

        case (r_state)
            wtfac_pkg::S_IDLE: begin
                // Take only the low WIDTH bits of the number
                if (i_in_valid) begin
                    n_num   = i_number[WIDTH-1:0];
                    n_cand  = WIDTH'(2);
                    n_pos   = '0;
                    n_tries = '0;
                    n_count = '0;
                    n_state = wtfac_pkg::S_TRY;
                end
            end
            wtfac_pkg::S_TRY: begin
                // Zero never factors; otherwise stop once the limit is spent
                if (r_num == '0 || (r_limit != '0 && r_tries >= r_limit)) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = wtfac_pkg::S_IDLE;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = wtfac_pkg::S_DIV;
                end
            end
            wtfac_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_state = wtfac_pkg::S_CHECK;
                end
            end
            wtfac_pkg::S_CHECK: begin
                // When a result is due, hold here until the output register can take it
                if (cand_over) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        em_value = r_num;
                        em_kind  = wtfac_pkg::KIND_COFACTOR;
                        n_state  = wtfac_pkg::S_IDLE;
                    end
                end else if (rem_zero) begin
                    if (out_free) begin
                        emit = 1'b1;
                        if (r_count == wtfac_pkg::CNT_W'(wtfac_pkg::MAX_RESULTS - 1)) begin
                            n_state = wtfac_pkg::S_IDLE;
                        end else begin
                            em_value = r_cand;
                            em_kind  = wtfac_pkg::KIND_DIVISOR;
                            em_last  = 1'b0;
                            n_num    = div_q;
                            n_tries  = '0;
                            n_count  = r_count + 1'b1;
                            n_state  = wtfac_pkg::S_TRY;
                        end
                    end
                end else if (step_sum[WIDTH]) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = wtfac_pkg::S_IDLE;
                    end
                end else begin
                    n_cand  = step_sum[WIDTH-1:0];
                    n_pos   = wtfac_pkg::wheel_next(r_pos);
                    n_tries = r_tries + 1'b1;
                    n_state = wtfac_pkg::S_TRY;
                end
            end
            default: begin
                n_state = wtfac_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: load on emit, drop once taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= em_value;
            r_out_kind  <= em_kind;
            r_out_last  <= em_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = wtfac_pkg::NUM_W'(r_out_value);
    assign o_kind      = r_out_kind;
    assign o_last      = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result emitted into a full output register");

    // The divider only finishes while the controller waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == wtfac_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    // Idle means no division is under way
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wtfac_pkg::S_IDLE |-> !div_stat.busy)
        else $error("divider busy while idle");

    // A launch is followed by a running divider
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> div_stat.busy && r_state == wtfac_pkg::S_DIV)
        else $error("divider did not start");

endmodule

@@ dv/wtfac_checker.sv @@
// ----------------------------------------------------------------------------
// wtfac_checker - result predictor and scoreboard for the wheel factoriser
// Snoops the number, result and APB channels, expands every accepted number
// into its expected factor sequence and compares the results in order.
// ----------------------------------------------------------------------------
module wtfac_checker #(
    parameter int WIDTH = wtfac_pkg::DEF_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [wtfac_pkg::NUM_W-1:0]   i_number,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [wtfac_pkg::NUM_W-1:0]   i_value,
    input  logic [1:0]                    i_kind,
    input  logic                          i_last,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [wtfac_pkg::PADDR_W-1:0] i_paddr,
    input  logic [wtfac_pkg::PDATA_W-1:0] i_pwdata,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] NUM_MASK = (WIDTH == 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
    localparam logic [10:0][2:0] WHEEL_GAPS =
        {3'd6, 3'd2, 3'd6, 3'd4, 3'd2, 3'd4, 3'd2, 3'd4, 3'd2, 3'd2, 3'd1};
    localparam logic [3:0] GAP_LAST = 4'd10;
    localparam logic [3:0] GAP_LOOP = 4'd3;

    typedef struct packed {
        logic [63:0]      value;
        wtfac_pkg::t_kind kind;
        logic             last;
    } t_factor_result;

    t_factor_result expected_factors[$];
    t_factor_result oldest;
    logic [31:0]    limit_reg;
    int             mismatches = 0;
    int             checked_results = 0;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] wanted);
        $display("[%0t] result %0d: %s is %0h, expected %0h",
                 $realtime, checked_results, field, got, wanted);
        mismatches++;
    endtask

    function automatic void add_factor(input logic [63:0] value,
                                       input wtfac_pkg::t_kind kind,
                                       input logic last);
        expected_factors.push_back('{value: value, kind: kind, last: last});
    endfunction

    // Trial division on the wheel, candidate by candidate
    function automatic void factorize_number(input logic [63:0] raw);
        logic [63:0] rest;
        logic [63:0] cand;
        logic [63:0] next_cand;
        logic [63:0] tries;
        logic [3:0]  pos;
        int          found;
        rest  = raw & NUM_MASK;
        cand  = 64'd2;
        pos   = '0;
        tries = '0;
        found = 0;
        if (rest == '0) begin
            add_factor('0, wtfac_pkg::KIND_GAVE_UP, 1'b1);
            return;
        end
        while (1'b1) begin
            tries++;
            if (limit_reg != '0 && tries > {32'd0, limit_reg}) begin
                add_factor('0, wtfac_pkg::KIND_GAVE_UP, 1'b1);
                return;
            end
            if (cand > NUM_MASK / cand || cand * cand > rest) begin
                add_factor(rest, wtfac_pkg::KIND_COFACTOR, 1'b1);
                return;
            end
            if (rest % cand == '0) begin
                if (found == wtfac_pkg::MAX_RESULTS - 1) begin
                    add_factor('0, wtfac_pkg::KIND_GAVE_UP, 1'b1);
                    return;
                end
                add_factor(cand, wtfac_pkg::KIND_DIVISOR, 1'b0);
                found++;
                rest  = rest / cand;
                tries = '0;
            end else begin
                next_cand = (cand + WHEEL_GAPS[pos]) & NUM_MASK;
                pos = (pos == GAP_LAST) ? GAP_LOOP : 4'(pos + 4'd1);
                if (next_cand <= cand) begin
                    add_factor('0, wtfac_pkg::KIND_GAVE_UP, 1'b1);
                    return;
                end
                cand = next_cand;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_reg = '0;
            expected_factors.delete();
        end else begin
            // Compare before predicting: a result never belongs to a number taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_factors.size() == 0) begin
                    report_mismatch("unexpected result, value", i_value, '0);
                end else begin
                    oldest = expected_factors.pop_front();
                    if (i_value !== oldest.value)
                        report_mismatch("value", i_value, oldest.value);
                    if (i_kind !== oldest.kind)
                        report_mismatch("kind", 64'(i_kind), 64'(oldest.kind));
                    if (i_last !== oldest.last)
                        report_mismatch("last", 64'(i_last), 64'(oldest.last));
                end
                checked_results++;
            end
            // A limit written at this edge already governs a number taken here
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[wtfac_pkg::PADDR_W-1:2] == wtfac_pkg::REG_LIMIT)
                limit_reg = i_pwdata;
            if (i_in_valid && i_in_ready)
                factorize_number(i_number);
        end
        o_pending <= expected_factors.size();
        o_errors  <= mismatches;
        o_results <= checked_results;
    end

endmodule

@@ dv/tb_wheel_trial_factorizer.sv @@
// ----------------------------------------------------------------------------
// tb_wheel_trial_factorizer - top-level testbench for the wheel factoriser
// Drives numbers and iteration limits into the block, lets the checker
// predict and compare every result, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_wheel_trial_factorizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH         = wtfac_pkg::DEF_WIDTH;
    // Settle long enough for two trial candidates
    localparam int SETTLE_CYCLES = 2 * (WIDTH + 3);
    // Longest quiet stretch of a correct run comes from the search on 997 squared
    localparam int QUIET_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 3000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [wtfac_pkg::NUM_W-1:0]     i_number;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [wtfac_pkg::NUM_W-1:0]     o_value;
    logic [1:0]                      o_kind;
    logic                            o_last;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [wtfac_pkg::PADDR_W-1:0]   paddr;
    logic [wtfac_pkg::PDATA_W-1:0]   pwdata;
    logic [wtfac_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;

    int errors;
    int pending;
    int results;

    // Idle percentages for each side, and the hold-off handshake between processes
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int numbers_sent   = 0;
    int limits_written = 0;

    wheel_trial_factorizer #(.WIDTH(WIDTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_number    (i_number),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_kind      (o_kind),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    wtfac_checker #(.WIDTH(WIDTH)) factor_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_number    (i_number),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_value     (o_value),
        .i_kind      (o_kind),
        .i_last      (o_last),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Number built from factors no larger than k and one final factor up to k squared,
    // so the wheel never has to climb past about k
    function automatic logic [63:0] smooth_number();
        logic [63:0]  n;
        logic [63:0]  cap;
        logic [63:0]  f;
        int unsigned  k;
        k   = $urandom_range(120, 6);
        n   = 64'd1;
        cap = 64'hFFFF_FFFF_FFFF_FFFF / (k * k);
        repeat ($urandom_range(60, 0)) begin
            f = 64'($urandom_range(k, 2));
            if (n <= cap / f)
                n = n * f;
        end
        f = 64'($urandom_range(k * k, 1));
        return n * f;
    endfunction

    // Half full-width noise: only safe while an iteration limit bounds the search
    function automatic logic [63:0] limited_number();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return {$urandom, $urandom};
            5, 6, 7:       return smooth_number();
            8:             return 64'($urandom_range(1000));
            default:       return 64'($urandom_range(1));
        endcase
    endfunction

    // Offer one number; valid stays high after acceptance so back-to-back items never drop it
    task automatic send_number(input logic [63:0] n);
        while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number   <= n;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        numbers_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] new_limit);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {wtfac_pkg::REG_LIMIT, 2'b00};
        pwdata  <= new_limit;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limits_written++;
    endtask

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct <= snd_pct;
        rcv_idle_pct <= rcv_pct;
    endtask

    // Result side: random stalls, or a long hold-off whenever one is requested
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Stop the run if no transaction of any kind moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        // Hold every input at a known value from time zero
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_number   <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases with the limit still at its reset value: unlimited search
        set_idling(33, 62);
        send_number(64'd0);                          // zero can only give up
        send_number(64'd1);                          // one is its own cofactor
        send_number(64'd2);
        send_number(64'd3);
        send_number(64'd4);
        send_number(64'd9);
        send_number(64'd25);
        send_number(64'd49);
        send_number(64'd30030);
        send_number(64'd1009);                       // prime just past the first squares
        send_number(64'd994009);                     // 997 squared: candidate square equals the number
        send_number(64'h8000_0000_0000_0000);        // sixty-three twos: most results in one run
        send_number(64'd614889782588491410);         // every prime up to 47 once
        send_number(64'd12157665459056928801);       // three to the fortieth, near the top of the range
        drain_results();

        // Smallest nonzero limit: each factor must be the very next candidate
        write_limit(32'd1);
        send_number(64'd5);
        send_number(64'hFFFF_FFFF_FFFF_FFFF);
        send_number(64'h1FFF_FFFF_FFFF_FFFF);        // large prime, gives up at once
        send_number(64'h8000_0000_0000_0000);
        send_number(64'd0);
        send_number(64'd1);
        drain_results();

        // Largest limit behaves as unlimited for small numbers
        write_limit(32'hFFFF_FFFF);
        send_number(64'd97);
        send_number(64'd3600);
        send_number(64'd1);
        drain_results();

        // Random numbers under a modest limit, sender lightly idle and receiver mostly idle
        write_limit($urandom_range(40, 8));
        repeat (40) send_number(limited_number());
        drain_results();

        // Unlimited search on smooth numbers, idling swapped
        write_limit(32'd0);
        set_idling(62, 33);
        repeat (40) send_number(smooth_number());
        drain_results();

        // No idling; open with a long output hold-off so the block backs up into its input
        write_limit($urandom_range(20, 3));
        set_idling(0, 0);
        hold_requests <= hold_requests + 1;
        repeat (40) send_number(limited_number());
        drain_results();

        $display("Sent %0d numbers and checked %0d results across %0d limit settings",
                 numbers_sent, results, limits_written + 1);
        $display("(zero, one, all-ones and random limits; both sides idling in turn; long stall)");
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
